// ===== hdl/wsaq_pkg.sv =====
// shared types and constants for the weighted score alert qualifier
// no dependencies; used by the channel interfaces and the top level
package wsaq_pkg;

    localparam int unsigned SCORE_W = 7;
    localparam int unsigned RUN_W   = 8;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;
    localparam logic [RUN_W-1:0]   RUN_MAX   = 8'd255;

    // reset values of the configuration registers
    localparam logic [SCORE_W-1:0] ELEV_THR_RST = 7'd60;
    localparam logic [SCORE_W-1:0] CRIT_THR_RST = 7'd80;
    localparam logic [RUN_W-1:0]   RUNS_RST     = 8'd3;

    // floor(x / 100) for x < 12800 as (x * 5243) >> 19
    localparam logic [12:0]  RECIP_FULL = 13'd5243;
    localparam int unsigned  SHIFT_FULL = 19;
    // floor(x / 15) for x < 2048 as (x * 2185) >> 15
    localparam logic [11:0]  RECIP_PART = 12'd2185;
    localparam int unsigned  SHIFT_PART = 15;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEV_THR = 2'd0,
        CFG_CRIT_THR = 2'd1,
        CFG_RUNS     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SCORE_W-1:0] metric_score;
        logic [SCORE_W-1:0] correlation_score;
        logic [SCORE_W-1:0] session_score;
        logic               session_valid;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] combined_score;
        logic               elevated_on;
        logic               critical_on;
        logic               elevated_raised;
        logic               elevated_cleared;
        logic               critical_raised;
        logic               critical_cleared;
    } t_out_item;

    typedef struct packed {
        logic             active;
        logic [RUN_W-1:0] high_run;
        logic [RUN_W-1:0] low_run;
    } t_level;

endpackage

// ===== hdl/wsaq_in_if.sv =====
// valid/ready channel carrying one input beat of sub-scores
// depends on wsaq_pkg for the payload type
interface wsaq_in_if;
    import wsaq_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/wsaq_out_if.sv =====
// valid/ready channel carrying one result beat
// depends on wsaq_pkg for the payload type
interface wsaq_out_if;
    import wsaq_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/weighted_score_alert_qualifier.sv =====
// Weighted score alert qualifier. Takes one beat per clock when the result side keeps
// up: a beat is captured in the input register, its combined score and both alert
// levels are worked out in one pass and written to the result register, from which
// the result is offered; the throughput is one beat per cycle, set by the single
// combinational pass between those two registers. The input ready follows the
// result ready combinationally through the two-entry pipeline. Configuration
// writes are taken at any edge and are meant for an idle block. There is no
// clearing pass after reset.
// depends on wsaq_pkg, wsaq_in_if and wsaq_out_if
module weighted_score_alert_qualifier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    wsaq_in_if.sink                          i_in,
    wsaq_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [wsaq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wsaq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wsaq_pkg::*;

    function automatic t_level f_level_next(t_level cur, logic hit, logic [RUN_W-1:0] need);
        t_level nxt;
        begin
            nxt = cur;
            if (hit) begin
                nxt.high_run = (cur.high_run == RUN_MAX) ? RUN_MAX : cur.high_run + 8'd1;
                nxt.low_run  = '0;
                if (!cur.active && nxt.high_run >= need) begin
                    nxt.active = 1'b1;
                end
            end else begin
                nxt.low_run  = (cur.low_run == RUN_MAX) ? RUN_MAX : cur.low_run + 8'd1;
                nxt.high_run = '0;
                if (cur.active && nxt.low_run >= need) begin
                    nxt.active = 1'b0;
                end
            end
            return nxt;
        end
    endfunction

    logic [SCORE_W-1:0] r_elev_thr;
    logic [SCORE_W-1:0] r_crit_thr;
    logic [RUN_W-1:0]   r_runs;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_level    r_elev;
    t_level    r_crit;

    logic      w_s2_load;
    logic      w_s1_load;
    logic      n_s1_valid;
    logic      n_out_valid;

    logic [13:0]        w_sum_full;
    logic [26:0]        w_prod_full;
    logic [10:0]        w_sum_part;
    logic [22:0]        w_prod_part;
    logic [7:0]         w_quot;
    logic [SCORE_W-1:0] w_score;
    t_level             n_elev;
    t_level             n_crit;
    t_out_item          n_out_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elev_thr <= ELEV_THR_RST;
            r_crit_thr <= CRIT_THR_RST;
            r_runs     <= RUNS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ELEV_THR: r_elev_thr <= i_cfg_data[SCORE_W-1:0];
                CFG_CRIT_THR: r_crit_thr <= i_cfg_data[SCORE_W-1:0];
                CFG_RUNS:     r_runs     <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign w_s2_load   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || w_s2_load;
    assign w_s1_load   = i_in.valid && i_in.ready;
    assign n_s1_valid  = w_s1_load || (r_s1_valid && !w_s2_load);
    assign n_out_valid = w_s2_load || (r_out_valid && !o_out.ready);

    // combined score, divisions by reciprocal multiply
    always_comb begin
        w_sum_full  = 14'(r_s1_item.metric_score) * 14'd40
                    + 14'(r_s1_item.correlation_score) * 14'd35
                    + 14'(r_s1_item.session_score) * 14'd25;
        w_prod_full = 27'(w_sum_full) * 27'(RECIP_FULL);
        w_sum_part  = 11'(r_s1_item.metric_score) * 11'd8
                    + 11'(r_s1_item.correlation_score) * 11'd7;
        w_prod_part = 23'(w_sum_part) * 23'(RECIP_PART);
        w_quot      = r_s1_item.session_valid ? w_prod_full[SHIFT_FULL +: 8]
                                              : w_prod_part[SHIFT_PART +: 8];
        w_score     = (w_quot > 8'(SCORE_MAX)) ? SCORE_MAX : w_quot[SCORE_W-1:0];
    end

    // alert levels
    always_comb begin
        n_elev = f_level_next(r_elev, w_score >= r_elev_thr, r_runs);
        n_crit = f_level_next(r_crit, w_score >= r_crit_thr, r_runs);

        n_out_item.combined_score   = w_score;
        n_out_item.elevated_on      = n_elev.active;
        n_out_item.critical_on      = n_crit.active;
        n_out_item.elevated_raised  = !r_elev.active && n_elev.active;
        n_out_item.elevated_cleared = r_elev.active && !n_elev.active;
        n_out_item.critical_raised  = !r_crit.active && n_crit.active;
        n_out_item.critical_cleared = r_crit.active && !n_crit.active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_elev      <= '0;
            r_crit      <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (w_s2_load) begin
                r_elev <= n_elev;
                r_crit <= n_crit;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_item <= i_in.data;
        end
        if (w_s2_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    // a level only changes when a beat moves into the result register
    a_elev_change_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_elev.active != $past(r_elev.active)) |-> $past(w_s2_load))
        else $error("elevated flag changed without a beat");

    // the two runs of one level are never both counting
    a_runs_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_elev.high_run == '0 || r_elev.low_run == '0)
        && (r_crit.high_run == '0 || r_crit.low_run == '0))
        else $error("high and low runs both nonzero");

    // a raise event comes with the flag set, a clear with it dropped
    a_event_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.data.elevated_raised || o_out.data.elevated_on)
                     && (!o_out.data.elevated_cleared || !o_out.data.elevated_on)
                     && (!o_out.data.critical_raised || o_out.data.critical_on)
                     && (!o_out.data.critical_cleared || !o_out.data.critical_on))
        else $error("alert event disagrees with flag");

    // score stays in range
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_s2_load) |-> (o_out.data.combined_score <= SCORE_MAX))
        else $error("combined score above maximum");

endmodule
